### hdl/pwm2ppm_pkg.sv
// Shared constants and types for the PWM capture to PPM encoder.
package pwm2ppm_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int TIMER_WIDTH  = 16;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
    localparam int SLOT_W       = $clog2(NUM_CHANNELS + 1);

    localparam int PIN_W        = 8;
    localparam int SLOT_OUT_W   = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int FRAMES_W     = 8;
    localparam int FS_CH_W      = 3;

    localparam logic [TIMER_WIDTH-1:0] INIT_WIDTH    = TIMER_WIDTH'(1000);
    localparam logic [15:0]            RST_SEPARATOR = 16'd300;
    localparam logic [15:0]            RST_SYNC      = 16'd5000;
    localparam logic [15:0]            RST_FS_WIDTH  = 16'd500;
    localparam logic [FRAMES_W-1:0]    RST_FS_FRAMES = FRAMES_W'(3);
    localparam logic [FS_CH_W-1:0]     RST_FS_CHAN   = FS_CH_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEPARATOR  = 3'd0,
        CFG_SYNC       = 3'd1,
        CFG_FS_WIDTH   = 3'd2,
        CFG_FS_FRAMES  = 3'd3,
        CFG_FS_CHANNEL = 3'd4
    } t_cfg_idx;

endpackage

### hdl/pwm_capture_to_ppm_encoder_top.sv
// Eight-channel RC PWM capture feeding a serial PPM frame generator.
//
// Input channel: one transfer per timer tick, carrying the levels of the
// eight PWM pins. Output channel: one transfer per tick with the PPM level,
// a frame start flag in the first tick of the sync pulse and the slot index.
// Configuration channel: register index and write data, always ready. The user
// must write registers only while no tick is in flight; the block does not enforce it.
//
// Each tick is captured in an input register and fully processed by one
// pass of combinational logic into the result register, so a result is
// offered once its tick has passed both registers; one tick is taken every
// cycle while results are taken. The only loop is the state feedback
// through that single pass (edge capture, phase counter, failsafe count).
// When the receiver stalls, the result register holds, the input register
// fills with one more tick, and then input ready drops.
// Reset empties both registers, loads all widths with 1000 and starts a
// separator phase with the reset separator length RST_SEPARATOR.
module pwm_capture_to_ppm_encoder_top
    import pwm2ppm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIN_W-1:0]      i_pin_levels,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_ppm_level,
    output logic                  o_frame_start,
    output logic [SLOT_OUT_W-1:0] o_slot_index,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [15:0]            r_separator;
    logic [15:0]            r_sync;
    logic [TIMER_WIDTH-1:0] r_fs_width;
    logic [FRAMES_W-1:0]    r_fs_frames;
    logic [FS_CH_W-1:0]     r_fs_channel;

    // Pipeline registers.
    logic                   r_in_valid;
    logic [NUM_CHANNELS-1:0] r_pins;
    logic                   r_out_valid;
    logic                   r_ppm_level;
    logic                   r_frame_start;
    logic [SLOT_OUT_W-1:0]  r_slot_index;

    // Block state.
    logic [TIMER_WIDTH-1:0]  r_tick;
    logic [TIMER_WIDTH-1:0]  r_rise  [NUM_CHANNELS];
    logic [TIMER_WIDTH-1:0]  r_width [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_prev;
    logic                    r_high;
    logic [SLOT_W-1:0]       r_slot;
    logic [15:0]             r_ticks_left;
    logic [FRAMES_W-1:0]     r_loss;

    logic [TIMER_WIDTH-1:0]  n_rise  [NUM_CHANNELS];
    logic [TIMER_WIDTH-1:0]  n_width [NUM_CHANNELS];
    logic                    n_high;
    logic [SLOT_W-1:0]       n_slot;
    logic [15:0]             n_ticks_left;
    logic [FRAMES_W-1:0]     n_loss;
    logic                    n_start;
    logic [SLOT_OUT_W-1:0]   n_slot_index;

    logic advance;
    logic process;

    assign advance     = !r_out_valid || i_out_ready;
    assign process     = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_ppm_level   = r_ppm_level;
    assign o_frame_start = r_frame_start;
    assign o_slot_index  = r_slot_index;

    always_comb begin
        n_loss = r_loss;
        for (int n = 0; n < NUM_CHANNELS; n++) begin
            n_rise[n]  = r_rise[n];
            n_width[n] = r_width[n];
            if (r_pins[n] && !r_prev[n]) begin
                n_rise[n] = r_tick;
            end else if (!r_pins[n] && r_prev[n]) begin
                n_width[n] = r_tick - r_rise[n];
                if (FS_CH_W'(n) == r_fs_channel) begin
                    n_loss = r_fs_frames;
                end
            end
        end

        n_high       = r_high;
        n_slot       = r_slot;
        n_ticks_left = r_ticks_left;
        n_start      = 1'b0;
        if (r_ticks_left != 16'd0) begin
            n_ticks_left = r_ticks_left - 16'd1;
        end else if (r_high) begin
            n_high       = 1'b0;
            n_ticks_left = r_separator;
        end else begin
            n_high = 1'b1;
            if (r_slot >= SLOT_W'(NUM_CHANNELS)) begin
                n_start      = 1'b1;
                n_ticks_left = r_sync;
                n_slot       = '0;
                // The failsafe check sees a loss count already refreshed by an
                // edge in this same tick.
                if (n_loss == '0) begin
                    if (32'(r_fs_channel) < NUM_CHANNELS) begin
                        n_width[CH_IDX_W'(r_fs_channel)] = r_fs_width;
                    end
                end else begin
                    n_loss = n_loss - FRAMES_W'(1);
                end
            end else begin
                n_ticks_left = 16'(n_width[r_slot[CH_IDX_W-1:0]]);
                n_slot       = r_slot + SLOT_W'(1);
            end
        end

        if (n_high) begin
            n_slot_index = (n_slot == '0) ? SLOT_OUT_W'(NUM_CHANNELS)
                                          : SLOT_OUT_W'(n_slot - SLOT_W'(1));
        end else begin
            n_slot_index = SLOT_OUT_W'(n_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator  <= RST_SEPARATOR;
            r_sync       <= RST_SYNC;
            r_fs_width   <= TIMER_WIDTH'(RST_FS_WIDTH);
            r_fs_frames  <= RST_FS_FRAMES;
            r_fs_channel <= RST_FS_CHAN;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SEPARATOR:  r_separator  <= i_cfg_data;
                CFG_SYNC:       r_sync       <= i_cfg_data;
                CFG_FS_WIDTH:   r_fs_width   <= TIMER_WIDTH'(i_cfg_data);
                CFG_FS_FRAMES:  r_fs_frames  <= i_cfg_data[FRAMES_W-1:0];
                CFG_FS_CHANNEL: r_fs_channel <= i_cfg_data[FS_CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pins <= NUM_CHANNELS'(i_pin_levels);
        end
        if (process) begin
            r_ppm_level   <= n_high;
            r_frame_start <= n_start;
            r_slot_index  <= n_slot_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_prev       <= '0;
            r_high       <= 1'b0;
            r_slot       <= '0;
            r_ticks_left <= RST_SEPARATOR;
            r_loss       <= '0;
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                r_rise[n]  <= '0;
                r_width[n] <= INIT_WIDTH;
            end
        end else if (process) begin
            r_tick       <= r_tick + TIMER_WIDTH'(1);
            r_prev       <= r_pins;
            r_high       <= n_high;
            r_slot       <= n_slot;
            r_ticks_left <= n_ticks_left;
            r_loss       <= n_loss;
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                r_rise[n]  <= n_rise[n];
                r_width[n] <= n_width[n];
            end
        end
    end

endmodule

### verif/testbench.sv
// Self-checking testbench for the PWM capture to PPM encoder, driven tick by tick.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pwm2ppm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned PRINT_LIMIT = 100;

    typedef struct packed {
        logic                  ppm_level;
        logic                  frame_start;
        logic [SLOT_OUT_W-1:0] slot_index;
    } t_ppm_tick;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [PIN_W-1:0]      i_pin_levels = '0;
    logic                  i_out_ready  = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_ppm_level;
    logic                  o_frame_start;
    logic [SLOT_OUT_W-1:0] o_slot_index;
    logic                  o_cfg_ready;

    pwm_capture_to_ppm_encoder_top uut (.*);

    always #5 i_clk = ~i_clk;

    // Encoder model: configuration copy and state.
    logic [15:0]            sep_len, sync_len, fs_width;
    logic [FRAMES_W-1:0]    fs_frames;
    logic [FS_CH_W-1:0]     fs_chan;
    logic [TIMER_WIDTH-1:0] tick_cnt;
    logic [TIMER_WIDTH-1:0] rise_at [NUM_CHANNELS];
    logic [TIMER_WIDTH-1:0] width_q [NUM_CHANNELS];
    logic [PIN_W-1:0]       prev_pins;
    logic                   ppm_high;
    logic [SLOT_OUT_W-1:0]  slot_cnt;
    logic [15:0]            phase_left;
    logic [FRAMES_W-1:0]    loss_cnt;

    t_ppm_tick   expected_ticks [$];
    int unsigned mismatch_count = 0;
    int unsigned checked_ticks  = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;

    // PWM waveform generator state.
    logic [PIN_W-1:0] gen_pins = '0;
    int unsigned      gen_left [PIN_W];

    task automatic reset_encoder_model();
        sep_len    = RST_SEPARATOR;
        sync_len   = RST_SYNC;
        fs_width   = RST_FS_WIDTH;
        fs_frames  = RST_FS_FRAMES;
        fs_chan    = RST_FS_CHAN;
        tick_cnt   = '0;
        prev_pins  = '0;
        ppm_high   = 1'b0;
        slot_cnt   = '0;
        phase_left = RST_SEPARATOR;
        loss_cnt   = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            rise_at[c] = '0;
            width_q[c] = INIT_WIDTH;
        end
        for (int c = 0; c < PIN_W; c++) begin
            gen_left[c] = 0;
        end
    endtask

    function automatic t_ppm_tick advance_encoder_model(input logic [PIN_W-1:0] pins);
        logic [PIN_W-1:0] toggled;
        t_ppm_tick        res;
        toggled = pins ^ prev_pins;
        res     = '0;
        // Edges are captured with the timer value before it advances.
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (toggled[c]) begin
                if (pins[c]) begin
                    rise_at[c] = tick_cnt;
                end else begin
                    width_q[c] = tick_cnt - rise_at[c];
                    if (c == int'(fs_chan)) begin
                        loss_cnt = fs_frames;
                    end
                end
            end
        end
        prev_pins = pins;
        if (phase_left != 0) begin
            phase_left = phase_left - 1'b1;
        end else if (ppm_high) begin
            ppm_high   = 1'b0;
            phase_left = sep_len;
        end else begin
            ppm_high = 1'b1;
            if (slot_cnt >= NUM_CHANNELS) begin
                res.frame_start = 1'b1;
                phase_left      = sync_len;
                slot_cnt        = '0;
                // The failsafe is checked once per frame at the sync pulse.
                if (loss_cnt == 0) begin
                    width_q[fs_chan] = fs_width;
                end else begin
                    loss_cnt = loss_cnt - 1'b1;
                end
            end else begin
                phase_left = width_q[slot_cnt];
                slot_cnt   = slot_cnt + 1'b1;
            end
        end
        res.ppm_level = ppm_high;
        if (ppm_high) begin
            res.slot_index = (slot_cnt == 0) ? SLOT_OUT_W'(NUM_CHANNELS) : slot_cnt - 1'b1;
        end else begin
            res.slot_index = slot_cnt;
        end
        tick_cnt = tick_cnt + 1'b1;
        return res;
    endfunction

    // Enabled channels toggle after random hold times or, at noise_pct percent, jump to random levels; masked stay low.
    function automatic logic [PIN_W-1:0] next_pin_levels(input int unsigned max_len,
                                                          input logic [PIN_W-1:0] mask,
                                                          input int unsigned noise_pct);
        if ($urandom_range(99) < noise_pct) begin
            gen_pins = PIN_W'($urandom) & mask;
        end else begin
            for (int c = 0; c < PIN_W; c++) begin
                if (gen_left[c] == 0) begin
                    gen_pins[c] = mask[c] ? ~gen_pins[c] : 1'b0;
                    gen_left[c] = $urandom_range(max_len, 1);
                end else begin
                    gen_left[c] = gen_left[c] - 1;
                end
            end
        end
        return gen_pins;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("ERROR at %0t ns, result %0d: %s", $time, checked_ticks, msg);
        end
        mismatch_count++;
    endtask

    task automatic send_tick(input logic [PIN_W-1:0] pins);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_pin_levels <= pins;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_ticks.push_back(advance_encoder_model(pins));
    endtask

    task automatic run_ticks(input int unsigned count, input int unsigned max_len,
                             input logic [PIN_W-1:0] mask, input int unsigned noise_pct);
        repeat (count) send_tick(next_pin_levels(max_len, mask, noise_pct));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SEPARATOR:  sep_len   = data;
            CFG_SYNC:       sync_len  = data;
            CFG_FS_WIDTH:   fs_width  = data;
            CFG_FS_FRAMES:  fs_frames = data[FRAMES_W-1:0];
            CFG_FS_CHANNEL: fs_chan   = data[FS_CH_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input logic [15:0] sep, input logic [15:0] sync,
                                 input logic [15:0] fsw, input logic [15:0] fsf,
                                 input logic [15:0] fsc);
        write_register(CFG_SEPARATOR, sep);
        write_register(CFG_SYNC, sync);
        write_register(CFG_FS_WIDTH, fsw);
        write_register(CFG_FS_FRAMES, fsf);
        write_register(CFG_FS_CHANNEL, fsc);
    endtask

    // Walking ones, all-high, all-low and alternating patterns under the reset configuration.
    task automatic test_pin_extremes();
        logic [PIN_W-1:0] pattern [20] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h04,
                                           8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h00, 8'hAA,
                                           8'h55, 8'hAA, 8'h00, 8'hFF, 8'h7F, 8'h00};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (pattern[k]) send_tick(pattern[k]);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Shortest phases, failsafe forcing of channel 0 at every frame, since the frame count is zero.
    task automatic test_minimum_settings();
        set_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_ticks(500, 8, 8'hFF, 3);
    endtask

    // The watched channel goes silent, so its width falls back to the failsafe value.
    task automatic test_lost_channel();
        set_registers(16'd3, 16'd20, 16'd7, 16'd2, 16'd5);
        send_idle_pct  = 64;
        recv_stall_pct = 0;
        run_ticks(250, 12, 8'hDF, 3);
        run_ticks(150, 12, 8'hFF, 3);
    endtask

    task automatic test_receiver_stalls();
        set_registers(16'd1, 16'd10, 16'd3, 16'd1, 16'd3);
        send_idle_pct  = 0;
        recv_stall_pct = 64;
        run_ticks(400, 20, 8'hFF, 3);
    endtask

    task automatic test_both_sides_idle();
        set_registers(16'd2, 16'd4, 16'd12, 16'd255, 16'd7);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        run_ticks(200, 10, 8'h7F, 3);
        run_ticks(200, 10, 8'hFF, 3);
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_left = 300;
        run_ticks(80, 12, 8'hFF, 0);
    endtask

    task automatic test_register_maximums();
        set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd7);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        run_ticks(150, 10, 8'hFF, 3);
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_ppm_tick want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_ticks.pop_front();
                if (o_ppm_level !== want.ppm_level) begin
                    report_mismatch($sformatf("ppm_level got %0b want %0b",
                                              o_ppm_level, want.ppm_level));
                end
                if (o_frame_start !== want.frame_start) begin
                    report_mismatch($sformatf("frame_start got %0b want %0b",
                                              o_frame_start, want.frame_start));
                end
                if (o_slot_index !== want.slot_index) begin
                    report_mismatch($sformatf("slot_index got %0d want %0d",
                                              o_slot_index, want.slot_index));
                end
            end
            checked_ticks++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        reset_encoder_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_pin_extremes();
        test_minimum_settings();
        test_lost_channel();
        test_receiver_stalls();
        test_both_sides_idle();
        test_backpressure();
        test_register_maximums();

        wait_results_drained();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
